>>> design/u16u8_pkg.sv
package u16u8_pkg;

	// Default depth of the job queue between front and back
	localparam int unsigned QDepth = 4;
	// Most bytes one code unit can cause: a flushed high surrogate plus a 3-byte unit
	localparam int unsigned JobBytes = 6;

	localparam logic [15:0] MaskAscii = 16'hFF80;
	localparam logic [15:0] MaskTwo   = 16'hF800;
	localparam logic [15:0] MaskSurr  = 16'hFC00;
	localparam logic [15:0] HighSurr  = 16'hD800;
	localparam logic [15:0] LowSurr   = 16'hDC00;

	localparam logic [7:0] LeadTwo   = 8'hC0;
	localparam logic [7:0] LeadThree = 8'hE0;
	localparam logic [7:0] LeadFour  = 8'hF0;
	localparam logic [7:0] ContByte  = 8'h80;

	localparam logic [20:0] PlaneBase = 21'h10000;

	typedef logic [2:0] cnt_t;

	typedef struct packed {
		logic [JobBytes-1:0][7:0] data;      // data[0] goes out first
		cnt_t                     cnt;       // bytes in this job, 1..6
		logic                     text_last; // job comes from the final unit of the text
	} job_t;

	// Three-byte form of a 16-bit unit, first byte in element 0
	function automatic logic [2:0][7:0] enc_three(input logic [15:0] u);
		logic [2:0][7:0] r;
		r[0] = LeadThree | {4'h0, u[15:12]};
		r[1] = ContByte  | {2'b00, u[11:6]};
		r[2] = ContByte  | {2'b00, u[5:0]};
		return r;
	endfunction

endpackage

>>> design/u16u8_ifs.sv
interface u16u8_unit_if;
	logic        valid;
	logic        ready;
	logic [15:0] code_unit;
	logic        last_unit;

	modport source(output valid, code_unit, last_unit, input ready);
	modport sink(input valid, code_unit, last_unit, output ready);
endinterface

interface u16u8_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_end;
	logic       text_end;

	modport source(output valid, out_byte, run_end, text_end, input ready);
	modport sink(input valid, out_byte, run_end, text_end, output ready);
endinterface

>>> design/utf16_to_utf8_encoder.sv
// Channel | Dir  | Payload                           | Request
// --------+------+-----------------------------------+------------------------------
// units   | sink | code_unit[15:0], last_unit        | one UTF-16 code unit
// utf8    | src  | out_byte[7:0], run_end, text_end  | one UTF-8 byte
//
// A unit causes 1 to 6 bytes, which the back serializer sends out one byte per
// cycle while utf8 is ready; a held high surrogate causes none by itself.
// The front classifies a unit in the cycle it is accepted and writes a job to
// the queue; units are taken every cycle until the queue is full.
// Reset clears the held surrogate, the queue and the output valid flag at once.
// A stall on utf8 holds the output byte and backs up into the queue, and into units.ready once the queue is full.
module utf16_to_utf8_encoder #(
	parameter int unsigned QDepth = u16u8_pkg::QDepth
) (
	input  logic         clk,
	input  logic         arst_n,
	u16u8_unit_if.sink   units,
	u16u8_byte_if.source utf8
);

	u16u8_pkg::job_t new_job;
	u16u8_pkg::job_t head_job;
	logic            job_push;
	logic            q_full;
	logic            q_avail;
	logic            q_pop;
	logic            accept;

	// Take a unit whenever the queue has room; a unit that causes no bytes
	// (high surrogate held for its partner) still needs no queue slot, but
	// keep the rule simple and uniform.
	assign units.ready = !q_full;
	assign accept      = units.valid && units.ready;

	// Front: surrogate tracking and byte formation for one unit per cycle while the queue has room
	u16u8_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.code_unit (units.code_unit),
		.last_unit (units.last_unit),
		.accept    (accept),
		.job       (new_job),
		.job_push  (job_push)
	);

	// Queue: decouple unit intake from the byte drain
	u16u8_fifo #(
		.Depth (QDepth)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (job_push),
		.push_job (new_job),
		.pop      (q_pop),
		.head     (head_job),
		.avail    (q_avail),
		.full     (q_full)
	);

	// Back: walk each job byte by byte into the output register
	u16u8_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head_job),
		.avail  (q_avail),
		.pop    (q_pop),
		.utf8   (utf8)
	);

endmodule

>>> design/u16u8_front.sv
module u16u8_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [15:0]        code_unit,
	input  logic               last_unit,
	input  logic               accept,
	output u16u8_pkg::job_t    job,
	output logic               job_push
);

	logic [15:0]     held_q;
	logic            held_valid_q;
	logic            is_low;
	logic            is_high;
	logic            pair;
	logic            flush;
	logic            hold;
	logic [2:0][7:0] cur_data;
	u16u8_pkg::cnt_t cur_cnt;
	logic [20:0]     cp;

	always_comb begin
		is_low  = (code_unit & u16u8_pkg::MaskSurr) == u16u8_pkg::LowSurr;
		is_high = (code_unit & u16u8_pkg::MaskSurr) == u16u8_pkg::HighSurr;
		pair    = held_valid_q && is_low;
		flush   = held_valid_q && !is_low;
		hold    = is_high && !last_unit;

		// encode the current unit on its own
		cur_data = '0;
		cur_cnt  = 3'd0;
		if ((code_unit & u16u8_pkg::MaskAscii) == 16'h0000) begin
			cur_data[0] = code_unit[7:0];
			cur_cnt     = 3'd1;
		end else if ((code_unit & u16u8_pkg::MaskTwo) == 16'h0000) begin
			cur_data[0] = u16u8_pkg::LeadTwo  | {3'b000, code_unit[10:6]};
			cur_data[1] = u16u8_pkg::ContByte | {2'b00, code_unit[5:0]};
			cur_cnt     = 3'd2;
		end else if (!hold) begin
			cur_data = u16u8_pkg::enc_three(code_unit);
			cur_cnt  = 3'd3;
		end

		cp = u16u8_pkg::PlaneBase + {1'b0, held_q[9:0], code_unit[9:0]};

		job           = '0;
		job.text_last = last_unit;
		if (pair) begin
			job.data[0] = u16u8_pkg::LeadFour | {5'b00000, cp[20:18]};
			job.data[1] = u16u8_pkg::ContByte | {2'b00, cp[17:12]};
			job.data[2] = u16u8_pkg::ContByte | {2'b00, cp[11:6]};
			job.data[3] = u16u8_pkg::ContByte | {2'b00, cp[5:0]};
			job.cnt     = 3'd4;
		end else if (flush) begin
			job.data[2:0] = u16u8_pkg::enc_three(held_q);
			job.data[5:3] = cur_data;
			job.cnt       = 3'd3 + cur_cnt;
		end else begin
			job.data[2:0] = cur_data;
			job.cnt       = cur_cnt;
		end

		job_push = accept && (job.cnt != 3'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q       <= '0;
			held_valid_q <= 1'b0;
		end else if (accept) begin
			if (!pair && hold) begin
				held_q       <= code_unit;
				held_valid_q <= 1'b1;
			end else begin
				held_q       <= '0;
				held_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> design/u16u8_fifo.sv
module u16u8_fifo #(
	parameter int unsigned Depth = u16u8_pkg::QDepth
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  u16u8_pkg::job_t push_job,
	input  logic            pop,
	output u16u8_pkg::job_t head,
	output logic            avail,
	output logic            full
);

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);

	u16u8_pkg::job_t mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] fill_q;
	logic            do_push;
	logic            do_pop;

	assign avail   = fill_q != '0;
	assign full    = fill_q == CntW'(Depth);
	assign do_push = push && !full;
	assign do_pop  = pop && avail;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

>>> design/u16u8_back.sv
module u16u8_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  u16u8_pkg::job_t      head,
	input  logic                 avail,
	output logic                 pop,
	u16u8_byte_if.source         utf8
);

	u16u8_pkg::job_t cur_q;
	logic            cur_valid_q;
	u16u8_pkg::cnt_t idx_q;
	logic            ovalid_q;
	logic [7:0]      obyte_q;
	logic            orun_q;
	logic            otext_q;
	logic            last_byte;
	logic            emit;
	logic            take;

	assign last_byte = idx_q == (cur_q.cnt - 3'd1);
	assign emit      = cur_valid_q && (!ovalid_q || utf8.ready);
	assign take      = !cur_valid_q || (emit && last_byte);
	assign pop       = take && avail;

	assign utf8.valid    = ovalid_q;
	assign utf8.out_byte = obyte_q;
	assign utf8.run_end  = orun_q;
	assign utf8.text_end = otext_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
			ovalid_q    <= 1'b0;
		end else begin
			if (emit) begin
				ovalid_q <= 1'b1;
			end else if (utf8.ready) begin
				ovalid_q <= 1'b0;
			end
			if (pop) begin
				cur_valid_q <= 1'b1;
				idx_q       <= '0;
			end else if (emit) begin
				if (last_byte) begin
					cur_valid_q <= 1'b0;
				end else begin
					idx_q <= idx_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
		if (emit) begin
			obyte_q <= cur_q.data[idx_q];
			orun_q  <= last_byte;
			otext_q <= last_byte && cur_q.text_last;
		end
	end

endmodule

>>> design/u16u8_chk.sv
module u16u8_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       valid,
	input logic       ready,
	input logic [7:0] out_byte,
	input logic       run_end,
	input logic       text_end
);

	// Hold a stalled byte and its flags
	assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid && $stable(out_byte) && $stable(run_end) && $stable(text_end))
		else $error("stalled byte changed");

	// End of text is always the end of a run
	assert property (@(posedge clk) disable iff (!arst_n)
		valid && text_end |-> run_end)
		else $error("text_end without run_end");

	// A lead byte never closes a run
	assert property (@(posedge clk) disable iff (!arst_n)
		valid && out_byte[7] && out_byte[6] |-> !run_end)
		else $error("run ends on a lead byte");

	// A single-byte character always closes its run
	assert property (@(posedge clk) disable iff (!arst_n)
		valid && !out_byte[7] |-> run_end)
		else $error("ASCII byte not at run end");

endmodule

bind utf16_to_utf8_encoder u16u8_chk u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.valid    (utf8.valid),
	.ready    (utf8.ready),
	.out_byte (utf8.out_byte),
	.run_end  (utf8.run_end),
	.text_end (utf8.text_end)
);
